/* rtl/pmt_evb_pkg.sv */
// Shared types and constants for the position PMT event builder.
// No dependencies; imported by every module of the block.
package pmt_evb_pkg;

  localparam int DEF_TIME_BITS   = 48;
  localparam int DEF_ENERGY_BITS = 13;

  localparam int CHAN_BITS      = 3;
  localparam int TRIG_BITS      = 13;
  localparam int WIN_BITS       = 16;
  localparam int COUNT_BITS     = 32;
  localparam int TOTAL_BITS     = 16;
  localparam int FRAC_BITS      = 16;
  localparam int POS_BITS       = FRAC_BITS + 1;
  localparam int NUM_ANODES     = 4;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_KICK_CHANNEL   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TIMING_CHANNEL = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRIGGER_LOW    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TRIGGER_HIGH   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COINC_WINDOW   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_POS_CHAN = 3'd5;

  // register reset values
  localparam logic [CHAN_BITS-1:0] RST_KICK_CHANNEL   = 3'd0;
  localparam logic [CHAN_BITS-1:0] RST_TIMING_CHANNEL = 3'd1;
  localparam logic [TRIG_BITS-1:0] RST_TRIGGER_LOW    = 13'd512;
  localparam logic [TRIG_BITS-1:0] RST_TRIGGER_HIGH   = 13'd8190;
  localparam logic [WIN_BITS-1:0]  RST_COINC_WINDOW   = 16'd1;
  localparam logic [CHAN_BITS-1:0] RST_FIRST_POS_CHAN = 3'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_X_START,
    ST_X_WAIT,
    ST_Y_START,
    ST_Y_WAIT,
    ST_OUT
  } state_e;

endpackage

/* rtl/position_pmt_event_builder_core.sv */
// Position PMT event builder: classifies hits, closes events, computes X/Y.
// A hit that closes no event leaves the input ready for the next hit; a closing hit
// stalls the input through accept, two passes of the shared serial divider and the
// result load (a pass is short if its sum or second anode is zero) and output stalls.
// Reset (rst_ni, async, low) restores register defaults and clears all event
// state; no clearing pass is needed. Results leave through an output register.
module position_pmt_event_builder_core import pmt_evb_pkg::*; #(
  parameter int TIME_BITS   = DEF_TIME_BITS,
  parameter int ENERGY_BITS = DEF_ENERGY_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i,
  // hit input
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [CHAN_BITS-1:0]      channel_i,
  input  logic [ENERGY_BITS-1:0]    energy_i,
  input  logic [TIME_BITS-1:0]      timestamp_i,
  // event output
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [ENERGY_BITS-1:0]    pulse_a_o,
  output logic [ENERGY_BITS-1:0]    pulse_b_o,
  output logic [ENERGY_BITS-1:0]    pulse_c_o,
  output logic [ENERGY_BITS-1:0]    pulse_d_o,
  output logic [TIME_BITS-1:0]      event_time_o,
  output logic signed [TIME_BITS:0] flight_time_o,
  output logic [TOTAL_BITS-1:0]     hit_total_o,
  output logic [COUNT_BITS-1:0]     kicker_total_o,
  output logic [COUNT_BITS-1:0]     timing_total_o,
  output logic signed [POS_BITS-1:0] x_position_o,
  output logic signed [POS_BITS-1:0] y_position_o
);

  localparam int CMP_BITS = (ENERGY_BITS > TRIG_BITS) ? ENERGY_BITS : TRIG_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CHAN_BITS-1:0] kick_chan_q, timing_chan_q, first_pos_q;
  logic [TRIG_BITS-1:0] trig_low_q, trig_high_q;
  logic [WIN_BITS-1:0]  window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kick_chan_q   <= RST_KICK_CHANNEL;
      timing_chan_q <= RST_TIMING_CHANNEL;
      trig_low_q    <= RST_TRIGGER_LOW;
      trig_high_q   <= RST_TRIGGER_HIGH;
      window_q      <= RST_COINC_WINDOW;
      first_pos_q   <= RST_FIRST_POS_CHAN;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_KICK_CHANNEL:   kick_chan_q   <= cfg_data_i[CHAN_BITS-1:0];
        REG_TIMING_CHANNEL: timing_chan_q <= cfg_data_i[CHAN_BITS-1:0];
        REG_TRIGGER_LOW:    trig_low_q    <= cfg_data_i[TRIG_BITS-1:0];
        REG_TRIGGER_HIGH:   trig_high_q   <= cfg_data_i[TRIG_BITS-1:0];
        REG_COINC_WINDOW:   window_q      <= cfg_data_i[WIN_BITS-1:0];
        REG_FIRST_POS_CHAN: first_pos_q   <= cfg_data_i[CHAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Event state
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [TIME_BITS-1:0]   event_start_q, event_start_d;
  logic [TIME_BITS-1:0]   kick_time_q, kick_time_d;
  logic [COUNT_BITS-1:0]  kick_cnt_q, kick_cnt_d;
  logic [COUNT_BITS-1:0]  tim_cnt_q, tim_cnt_d;
  logic                   kick_pend_q, kick_pend_d;
  logic                   tim_pend_q, tim_pend_d;
  logic [ENERGY_BITS-1:0] pulse_q [NUM_ANODES];
  logic [ENERGY_BITS-1:0] pulse_d [NUM_ANODES];
  logic [TOTAL_BITS-1:0]  hits_q  [NUM_ANODES];
  logic [TOTAL_BITS-1:0]  hits_d  [NUM_ANODES];

  logic                   accept;
  logic                   in_window;
  logic                   is_kick, is_tim;
  logic [TIME_BITS-1:0]   time_diff;
  logic                   late;
  logic                   flush;
  logic [CHAN_BITS-1:0]   rel_chan;
  logic                   is_pos;
  logic [TIME_BITS:0]     flight;
  logic [TOTAL_BITS+1:0]  total_sum;
  logic [TOTAL_BITS-1:0]  total_sat;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_window = (CMP_BITS'(energy_i) > CMP_BITS'(trig_low_q)) &&
                     (CMP_BITS'(energy_i) < CMP_BITS'(trig_high_q));
  assign is_kick   = (channel_i == kick_chan_q) && in_window;
  assign is_tim    = !is_kick && (channel_i == timing_chan_q) && in_window;

  // a timestamp behind the event start never counts as late
  assign time_diff = timestamp_i - event_start_q;
  assign late      = (timestamp_i > event_start_q) &&
                     (time_diff > TIME_BITS'(window_q));

  assign rel_chan  = channel_i - first_pos_q;
  assign is_pos    = (channel_i >= first_pos_q) && (rel_chan < CHAN_BITS'(NUM_ANODES));

  // flight time uses the kicker time after this hit
  assign flight    = {1'b0, event_start_q} - {1'b0, kick_time_d};

  assign total_sum = (TOTAL_BITS+2)'(hits_q[0]) + (TOTAL_BITS+2)'(hits_q[1]) +
                     (TOTAL_BITS+2)'(hits_q[2]) + (TOTAL_BITS+2)'(hits_q[3]);
  assign total_sat = (total_sum[TOTAL_BITS+1:TOTAL_BITS] != 2'b00) ? '1
                                                                 : total_sum[TOTAL_BITS-1:0];

  always_comb begin
    kick_cnt_d  = kick_cnt_q + COUNT_BITS'(is_kick);
    tim_cnt_d   = tim_cnt_q + COUNT_BITS'(is_tim);
    kick_time_d = is_kick ? timestamp_i : kick_time_q;
    kick_pend_d = kick_pend_q || is_kick;
    tim_pend_d  = tim_pend_q || is_tim;
    // nothing is emitted until a kicker has been seen
    flush = ((kick_cnt_d != '0) || kick_pend_d) && (late || kick_pend_d || tim_pend_d);
    event_start_d = event_start_q;
    if (flush) begin
      kick_pend_d   = 1'b0;
      tim_pend_d    = 1'b0;
      event_start_d = timestamp_i;
    end
    for (int i = 0; i < NUM_ANODES; i++) begin
      pulse_d[i] = flush ? '0 : pulse_q[i];
      hits_d[i]  = flush ? '0 : hits_q[i];
      if (is_pos && (rel_chan[1:0] == 2'(i))) begin
        pulse_d[i] = energy_i;
        if (hits_d[i] != '1) begin
          hits_d[i] = hits_d[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_start_q <= '0;
      kick_time_q   <= '0;
      kick_cnt_q    <= '0;
      tim_cnt_q     <= '0;
      kick_pend_q   <= 1'b0;
      tim_pend_q    <= 1'b0;
      for (int i = 0; i < NUM_ANODES; i++) begin
        pulse_q[i] <= '0;
        hits_q[i]  <= '0;
      end
    end else if (accept) begin
      event_start_q <= event_start_d;
      kick_time_q   <= kick_time_d;
      kick_cnt_q    <= kick_cnt_d;
      tim_cnt_q     <= tim_cnt_d;
      kick_pend_q   <= kick_pend_d;
      tim_pend_q    <= tim_pend_d;
      for (int i = 0; i < NUM_ANODES; i++) begin
        pulse_q[i] <= pulse_d[i];
        hits_q[i]  <= hits_d[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Snapshot of the closed event, held while X and Y are computed
  // ---------------------------------------------------------------------------
  logic [ENERGY_BITS-1:0] snap_pulse_q [NUM_ANODES];
  logic [TIME_BITS-1:0]   snap_time_q;
  logic [TIME_BITS:0]     snap_flight_q;
  logic [TOTAL_BITS-1:0]  snap_total_q;
  logic [COUNT_BITS-1:0]  snap_kick_q, snap_tim_q;
  logic [POS_BITS-1:0]    snap_x_q;

  logic                   div_start;
  logic                   div_sel_y;
  logic                   div_done;
  logic [POS_BITS-1:0]    div_quot;
  logic                   load_out;

  always_ff @(posedge clk_i) begin
    if (accept && flush) begin
      for (int i = 0; i < NUM_ANODES; i++) begin
        snap_pulse_q[i] <= pulse_q[i];
      end
      snap_time_q   <= event_start_q;
      snap_flight_q <= flight;
      snap_total_q  <= total_sat;
      snap_kick_q   <= kick_cnt_d;
      snap_tim_q    <= tim_cnt_d;
    end
    if ((state_q == ST_X_WAIT) && div_done) begin
      snap_x_q <= div_quot;
    end
  end

  // one fraction unit, used for X (a, b) then Y (c, d)
  pmt_evb_frac #(
    .ENERGY_BITS(ENERGY_BITS)
  ) u_frac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_sel_y ? snap_pulse_q[2] : snap_pulse_q[0]),
    .other_i (div_sel_y ? snap_pulse_q[3] : snap_pulse_q[1]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (accept && flush) state_d = ST_X_START;
      ST_X_START: state_d = ST_X_WAIT;
      ST_X_WAIT:  if (div_done) state_d = ST_Y_START;
      ST_Y_START: state_d = ST_Y_WAIT;
      ST_Y_WAIT:  if (div_done) state_d = ST_OUT;
      ST_OUT:     if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    div_sel_y  = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE:    in_stall_o = 1'b0;
      ST_X_START: div_start  = 1'b1;
      ST_X_WAIT:  ;
      ST_Y_START: begin
        div_start = 1'b1;
        div_sel_y = 1'b1;
      end
      ST_Y_WAIT:  div_sel_y = 1'b1;
      ST_OUT:     load_out  = !out_valid_q || !out_stall_i;
      default:    ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [POS_BITS-1:0] y_hold_q;

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_Y_WAIT) && div_done) begin
      y_hold_q <= div_quot;
    end
    if (load_out) begin
      pulse_a_o      <= snap_pulse_q[0];
      pulse_b_o      <= snap_pulse_q[1];
      pulse_c_o      <= snap_pulse_q[2];
      pulse_d_o      <= snap_pulse_q[3];
      event_time_o   <= snap_time_q;
      flight_time_o  <= snap_flight_q;
      hit_total_o    <= snap_total_q;
      kicker_total_o <= snap_kick_q;
      timing_total_o <= snap_tim_q;
      x_position_o   <= snap_x_q;
      y_position_o   <= y_hold_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/pmt_evb_frac.sv */
// Iterative fraction unit: num * 2^16 / (num + other), one quotient bit a cycle.
// Saturates at 65535, returns all ones when the sum is zero. Uses pmt_evb_pkg.
module pmt_evb_frac import pmt_evb_pkg::*; #(
  parameter int ENERGY_BITS = DEF_ENERGY_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [ENERGY_BITS-1:0] num_i,
  input  logic [ENERGY_BITS-1:0] other_i,
  output logic                   done_o,
  output logic [POS_BITS-1:0]    quot_o
);

  localparam int CNT_BITS = $clog2(FRAC_BITS);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [ENERGY_BITS:0]  rem_q, rem_d;
  logic [ENERGY_BITS:0]  sum_q, sum_d;
  logic [POS_BITS-1:0]   quot_q, quot_d;
  logic [ENERGY_BITS:0]  sum_in;
  logic [ENERGY_BITS+1:0] rem2;
  logic [ENERGY_BITS+1:0] rem_sub;
  logic                  ge;

  assign sum_in  = {1'b0, num_i} + {1'b0, other_i};
  assign rem2    = {rem_q, 1'b0};
  assign rem_sub = rem2 - {1'b0, sum_q};
  assign ge      = (rem2 >= {1'b0, sum_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sum_d  = sum_q;
    quot_d = quot_q;
    if (start_i) begin
      if (sum_in == '0) begin
        quot_d = '1;
        done_d = 1'b1;
      end else if (other_i == '0) begin
        quot_d = {1'b0, {FRAC_BITS{1'b1}}};
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        cnt_d  = '0;
        rem_d  = {1'b0, num_i};
        sum_d  = sum_in;
        quot_d = '0;
      end
    end else if (busy_q) begin
      // remainder stays below the sum, so it fits ENERGY_BITS+1 bits
      rem_d  = ge ? rem_sub[ENERGY_BITS:0] : rem2[ENERGY_BITS:0];
      quot_d = {quot_q[POS_BITS-2:0], ge};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_BITS'(FRAC_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    sum_q  <= sum_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* test/tb.sv */
// Testbench for position_pmt_event_builder_core: directed and random hit streams,
// with every closed event checked against a cycle-free model of the event builder.
// Depends on rtl/pmt_evb_pkg.sv and rtl/position_pmt_event_builder_core.sv.
`timescale 1ns / 100ps

module tb;
  import pmt_evb_pkg::*;

  localparam int TW = DEF_TIME_BITS;
  localparam int EW = DEF_ENERGY_BITS;

  localparam int RESET_CYCLES    = 9;
  // a closing hit keeps the block busy through both divider passes; give it margin
  localparam int DRAIN_CYCLES    = 48;
  // longest quiet stretch in a correct run: drain + one event + receiver stall
  // run + sender gap, well under IDLE_LIMIT
  localparam int IDLE_LIMIT      = 3000;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int COUNT_HITS      = 40;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_e;

  typedef struct {
    logic [EW-1:0]             pulse_a;
    logic [EW-1:0]             pulse_b;
    logic [EW-1:0]             pulse_c;
    logic [EW-1:0]             pulse_d;
    logic [TW-1:0]             event_time;
    logic signed [TW:0]        flight_time;
    logic [TOTAL_BITS-1:0]     hit_total;
    logic [COUNT_BITS-1:0]     kicker_total;
    logic [COUNT_BITS-1:0]     timing_total;
    logic signed [POS_BITS-1:0] x_position;
    logic signed [POS_BITS-1:0] y_position;
  } pmt_event_t;

  // ---------------------------------------------------------------------------
  // DUT signals, all inputs driven to known values from time zero
  // ---------------------------------------------------------------------------
  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i  = '0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic [CHAN_BITS-1:0]      channel_i   = '0;
  logic [EW-1:0]             energy_i    = '0;
  logic [TW-1:0]             timestamp_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [EW-1:0]             pulse_a_o;
  logic [EW-1:0]             pulse_b_o;
  logic [EW-1:0]             pulse_c_o;
  logic [EW-1:0]             pulse_d_o;
  logic [TW-1:0]             event_time_o;
  logic signed [TW:0]        flight_time_o;
  logic [TOTAL_BITS-1:0]     hit_total_o;
  logic [COUNT_BITS-1:0]     kicker_total_o;
  logic [COUNT_BITS-1:0]     timing_total_o;
  logic signed [POS_BITS-1:0] x_position_o;
  logic signed [POS_BITS-1:0] y_position_o;

  position_pmt_event_builder_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .channel_i      (channel_i),
    .energy_i       (energy_i),
    .timestamp_i    (timestamp_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pulse_a_o      (pulse_a_o),
    .pulse_b_o      (pulse_b_o),
    .pulse_c_o      (pulse_c_o),
    .pulse_d_o      (pulse_d_o),
    .event_time_o   (event_time_o),
    .flight_time_o  (flight_time_o),
    .hit_total_o    (hit_total_o),
    .kicker_total_o (kicker_total_o),
    .timing_total_o (timing_total_o),
    .x_position_o   (x_position_o),
    .y_position_o   (y_position_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Event builder model: register copy plus event state, reset values as in
  // the package. Reset happens once, so initializers are enough.
  // ---------------------------------------------------------------------------
  logic [CHAN_BITS-1:0]  cfg_kick_ch   = RST_KICK_CHANNEL;
  logic [CHAN_BITS-1:0]  cfg_timing_ch = RST_TIMING_CHANNEL;
  logic [TRIG_BITS-1:0]  cfg_trig_lo   = RST_TRIGGER_LOW;
  logic [TRIG_BITS-1:0]  cfg_trig_hi   = RST_TRIGGER_HIGH;
  logic [WIN_BITS-1:0]   cfg_window    = RST_COINC_WINDOW;
  logic [CHAN_BITS-1:0]  cfg_first_pos = RST_FIRST_POS_CHAN;

  logic [TW-1:0]         event_start    = '0;
  logic [EW-1:0]         last_height[NUM_ANODES] = '{default: '0};
  logic [TOTAL_BITS-1:0] anode_hits[NUM_ANODES]  = '{default: '0};
  logic [TW-1:0]         kicker_time    = '0;
  logic [COUNT_BITS-1:0] kicker_count   = '0;
  logic [COUNT_BITS-1:0] timing_count   = '0;
  logic                  kicker_pending = 1'b0;
  logic                  timing_pending = 1'b0;

  pmt_event_t expected_events[$];
  int         mismatch_count = 0;

  // sender and receiver pacing
  int          burst_max  = 4;
  int          gap_max    = 3;
  int          burst_left = 0;
  stall_mode_e stall_mode = STALL_LIGHT;
  logic [TW-1:0] hit_clock = '0;

  // floor(num * 2^16 / (num + other)), clipped to 16 bits; all ones on 0/0
  function automatic logic signed [POS_BITS-1:0] anode_fraction(
    input logic [EW-1:0] num, input logic [EW-1:0] other);
    logic [EW:0]              sum;
    logic [EW+FRAC_BITS-1:0]  quotient;
    sum = {1'b0, num} + {1'b0, other};
    if (sum == '0) return '1;
    quotient = {num, {FRAC_BITS{1'b0}}} / (EW+FRAC_BITS)'(sum);
    if (quotient[EW+FRAC_BITS-1:FRAC_BITS] != '0) return {1'b0, {FRAC_BITS{1'b1}}};
    return quotient[POS_BITS-1:0];
  endfunction

  // One accepted hit: classify it, close the open event if due, then store it
  // as an anode hit. A closed event goes on the expected queue.
  task automatic predict_hit(input logic [CHAN_BITS-1:0] ch, input logic [EW-1:0] e,
                             input logic [TW-1:0] t);
    logic                  in_window;
    logic                  late;
    logic [TW-1:0]         since_start;
    logic [TOTAL_BITS+1:0] total;
    pmt_event_t            ev;
    int                    k;
    in_window = (e > cfg_trig_lo) && (e < cfg_trig_hi);
    // kicker test wins when both channels are the same
    if (ch == cfg_kick_ch && in_window) begin
      kicker_count++;
      kicker_time    = t;
      kicker_pending = 1'b1;
    end else if (ch == cfg_timing_ch && in_window) begin
      timing_count++;
      timing_pending = 1'b1;
    end
    // a time behind the event start is never late
    since_start = t - event_start;
    late = (t > event_start) && (since_start > TW'(cfg_window));
    if ((kicker_count != 0 || kicker_pending) && (late || kicker_pending || timing_pending)) begin
      total = (TOTAL_BITS+2)'(anode_hits[0]) + (TOTAL_BITS+2)'(anode_hits[1]) +
              (TOTAL_BITS+2)'(anode_hits[2]) + (TOTAL_BITS+2)'(anode_hits[3]);
      ev.pulse_a      = last_height[0];
      ev.pulse_b      = last_height[1];
      ev.pulse_c      = last_height[2];
      ev.pulse_d      = last_height[3];
      ev.event_time   = event_start;
      ev.flight_time  = {1'b0, event_start} - {1'b0, kicker_time};
      ev.hit_total    = (total[TOTAL_BITS+1:TOTAL_BITS] != 2'b00) ? '1
                                                                 : total[TOTAL_BITS-1:0];
      ev.kicker_total = kicker_count;
      ev.timing_total = timing_count;
      ev.x_position   = anode_fraction(last_height[0], last_height[1]);
      ev.y_position   = anode_fraction(last_height[2], last_height[3]);
      expected_events.push_back(ev);
      kicker_pending = 1'b0;
      timing_pending = 1'b0;
      foreach (last_height[i]) begin
        last_height[i] = '0;
        anode_hits[i]  = '0;
      end
      event_start = t;
    end
    // trigger hits on an anode channel are stored too; anodes past 7 never fire
    k = int'(ch) - int'(cfg_first_pos);
    if (k >= 0 && k < NUM_ANODES) begin
      if (anode_hits[k] != '1) anode_hits[k]++;
      last_height[k] = e;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: every accepted event against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : event_checker
    pmt_event_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: event with none expected, event_time %h", $time, event_time_o);
      end else begin
        want = expected_events.pop_front();
        check_field("pulse_a", 64'(want.pulse_a), 64'(pulse_a_o));
        check_field("pulse_b", 64'(want.pulse_b), 64'(pulse_b_o));
        check_field("pulse_c", 64'(want.pulse_c), 64'(pulse_c_o));
        check_field("pulse_d", 64'(want.pulse_d), 64'(pulse_d_o));
        check_field("event_time", 64'(want.event_time), 64'(event_time_o));
        check_field("flight_time", 64'(want.flight_time), 64'(flight_time_o));
        check_field("hit_total", 64'(want.hit_total), 64'(hit_total_o));
        check_field("kicker_total", 64'(want.kicker_total), 64'(kicker_total_o));
        check_field("timing_total", 64'(want.timing_total), 64'(timing_total_o));
        check_field("x_position", 64'(want.x_position), 64'(x_position_o));
        check_field("y_position", 64'(want.y_position), 64'(y_position_o));
      end
    end
  end

  // Receiver back-pressure: runs of stall/no-stall whose density follows
  // stall_mode. One nonblocking write per edge.
  int   stall_run = 0;
  logic stalling  = 1'b0;

  always @(posedge clk_i) begin
    if (stall_run > 0) begin
      stall_run--;
    end else begin
      case (stall_mode)
        STALL_NONE: begin
          stalling  = 1'b0;
          stall_run = 16;
        end
        STALL_LIGHT: begin
          stalling  = ($urandom_range(0, 3) == 0);
          stall_run = $urandom_range(0, 4);
        end
        default: begin
          stalling  = ($urandom_range(0, 1) == 0);
          stall_run = $urandom_range(0, 15);
        end
      endcase
    end
    out_stall_i <= stalling;
  end

  // Watchdog: any handshake or register write counts as progress
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers; all are entered and left on a rising edge
  // ---------------------------------------------------------------------------

  // Present one hit, wait for acceptance, then either keep valid up for the
  // next item of the burst or drop it for a random gap.
  task automatic send_hit(input logic [CHAN_BITS-1:0] ch, input logic [EW-1:0] e,
                          input logic [TW-1:0] t);
    in_valid_i  <= 1'b1;
    channel_i   <= ch;
    energy_i    <= e;
    timestamp_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    predict_hit(ch, e, t);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, burst_max);
      if (gap_max > 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      end
    end
  endtask

  // Sender holds off until every expected event is out and the block is idle
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      REG_KICK_CHANNEL:   cfg_kick_ch   = data[CHAN_BITS-1:0];
      REG_TIMING_CHANNEL: cfg_timing_ch = data[CHAN_BITS-1:0];
      REG_TRIGGER_LOW:    cfg_trig_lo   = data[TRIG_BITS-1:0];
      REG_TRIGGER_HIGH:   cfg_trig_hi   = data[TRIG_BITS-1:0];
      REG_COINC_WINDOW:   cfg_window    = data[WIN_BITS-1:0];
      REG_FIRST_POS_CHAN: cfg_first_pos = data[CHAN_BITS-1:0];
      default: ;
    endcase
  endtask

  // Drains first, so writes only land while the block is idle
  task automatic program_registers(input int kick, input int timing, input int lo,
                                   input int hi, input int window, input int first_pos);
    wait_until_drained();
    write_reg(REG_KICK_CHANNEL, CFG_DATA_BITS'(kick));
    write_reg(REG_TIMING_CHANNEL, CFG_DATA_BITS'(timing));
    write_reg(REG_TRIGGER_LOW, CFG_DATA_BITS'(lo));
    write_reg(REG_TRIGGER_HIGH, CFG_DATA_BITS'(hi));
    write_reg(REG_COINC_WINDOW, CFG_DATA_BITS'(window));
    write_reg(REG_FIRST_POS_CHAN, CFG_DATA_BITS'(first_pos));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [EW-1:0] any_energy();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return EW'($urandom);
    endcase
  endfunction

  // mostly inside the trigger window, sometimes exactly on its edges
  function automatic logic [EW-1:0] trigger_energy();
    int lo;
    int hi;
    lo = int'(cfg_trig_lo);
    hi = int'(cfg_trig_hi);
    if (hi - lo >= 2 && $urandom_range(0, 7) != 0) return EW'($urandom_range(lo + 1, hi - 1));
    return $urandom_range(0, 1) ? cfg_trig_lo : cfg_trig_hi;
  endfunction

  // mostly forward steps around the coincidence window, rarely big jumps
  // (which also wrap the 48-bit clock) or steps backwards
  task automatic advance_clock();
    int pick;
    int win;
    pick = $urandom_range(0, 99);
    win  = int'(cfg_window);
    if (pick < 45)      hit_clock += TW'($urandom_range(0, win));
    else if (pick < 85) hit_clock += TW'(win + $urandom_range(1, 3));
    else if (pick < 97) hit_clock += TW'($urandom_range(0, 2 * win + 4));
    else if (pick < 99) hit_clock = TW'({$urandom, $urandom});
    else                hit_clock -= TW'($urandom_range(1, win + 2));
  endtask

  task automatic send_random_hit();
    logic [CHAN_BITS-1:0] ch;
    logic [EW-1:0]        e;
    int                   pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      ch = cfg_kick_ch;
      e  = trigger_energy();
    end else if (pick < 20) begin
      ch = cfg_timing_ch;
      e  = trigger_energy();
    end else if (pick < 75) begin
      ch = cfg_first_pos + CHAN_BITS'($urandom_range(0, 3));
      e  = any_energy();
    end else begin
      ch = CHAN_BITS'($urandom);
      e  = any_energy();
    end
    advance_clock();
    send_hit(ch, e, hit_clock);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers still at reset values: kicker ch0, timing ch1, window (512,8190),
  // coincidence 1, anodes on ch2..5.
  task automatic test_default_registers();
    // nothing closes before the first kicker, but anode hits are kept and a
    // timing pulse stays pending
    send_hit(3'd2, 13'd100, 48'd10);
    send_hit(3'd1, 13'd1000, 48'd11);
    send_hit(3'd3, 13'd8191, 48'd12);
    // first kicker closes the event: negative flight time, Y = -1
    send_hit(3'd0, 13'd513, 48'd12);
    // heights equal to the trigger limits are not triggers
    send_hit(3'd0, 13'd512, 48'd12);
    send_hit(3'd0, 13'd8190, 48'd12);
    // exactly one window later is still inside the event
    send_hit(3'd4, 13'd0, 48'd13);
    send_hit(3'd5, 13'd8191, 48'd13);
    // one tick past the window closes it: X = -1, Y = 0
    send_hit(3'd2, 13'd8191, 48'd14);
    // time going backwards never counts as late
    send_hit(3'd3, 13'd0, 48'd5);
    // timing pulse at the top of the window closes; X saturates with b = 0
    send_hit(3'd1, 13'd8189, 48'd5);
  endtask

  // Kicker and timing on the same anode channel, widest trigger window,
  // zero coincidence window
  task automatic test_shared_trigger_channel();
    program_registers(3, 3, 0, 8191, 0, 0);
    send_hit(3'd3, 13'd1, 48'd100);
    send_hit(3'd3, 13'd1, 48'd100);
    send_hit(3'd0, 13'd0, 48'd100);
    send_hit(3'd0, 13'd5, 48'd101);
  endtask

  // Anodes partly past channel 7, widest coincidence window, top of time range
  task automatic test_high_anodes_and_time_wrap();
    program_registers(7, 6, 100, 200, 65535, 6);
    send_hit(3'd6, 13'd150, 48'd200);
    send_hit(3'd7, 13'd150, 48'd300);
    send_hit(3'd0, 13'd4000, {TW{1'b1}});
    send_hit(3'd7, 13'd199, {TW{1'b1}});
    program_registers(0, 7, 512, 8190, 2, 7);
    send_hit(3'd7, 13'd3000, 48'd7);
    send_hit(3'd0, 13'd600, 48'd9);
  endtask

  // Per-anode counters and the hit total over one long event, back to back
  task automatic test_hit_counting();
    int start_time;
    program_registers(7, 6, 512, 8190, 65535, 0);
    burst_max  = COUNT_HITS;
    gap_max    = 0;
    stall_mode = STALL_NONE;
    start_time = 1000;
    send_hit(3'd7, 13'd1000, TW'(start_time));
    repeat (COUNT_HITS) send_hit(3'd0, EW'($urandom), TW'(start_time));
    send_hit(3'd1, 13'd77, TW'(start_time));
    send_hit(3'd2, 13'd0, TW'(start_time));
    send_hit(3'd3, 13'd8191, TW'(start_time));
    send_hit(3'd7, 13'd1000, TW'(start_time));
  endtask

  // Random hits over several register settings and pacing styles
  task automatic test_random_traffic();
    int lo;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: program_registers(int'(RST_KICK_CHANNEL), int'(RST_TIMING_CHANNEL),
                             int'(RST_TRIGGER_LOW), int'(RST_TRIGGER_HIGH),
                             int'(RST_COINC_WINDOW), int'(RST_FIRST_POS_CHAN));
        1: program_registers(7, 0, 0, 8191, 0, 4);
        2: program_registers(2, 2, 4000, 4100, 65535, 0);
        // empty trigger window: events close on lateness alone
        3: program_registers(5, 6, 8191, 0, 3, 1);
        default: begin
          lo = $urandom_range(0, 6000);
          program_registers($urandom_range(0, 7), $urandom_range(0, 7), lo,
                            $urandom_range(lo, 8191),
                            ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 40),
                            $urandom_range(0, 7));
        end
      endcase
      stall_mode = stall_mode_e'((phase + 1) % 3);
      gap_max    = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 3 : 10);
      burst_max  = (phase % 3 == 2) ? 4 : 30;
      burst_left = 0;
      hit_clock  = (phase == 0) ? '0 : TW'({$urandom, $urandom});
      repeat (ITEMS_PER_PHASE) send_random_hit();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_registers();
    test_shared_trigger_channel();
    test_high_anodes_and_time_wrap();
    test_hit_counting();
    test_random_traffic();
    wait_until_drained();
    if (mismatch_count == 0 && expected_events.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
rtl/pmt_evb_pkg.sv
rtl/pmt_evb_frac.sv
rtl/position_pmt_event_builder_core.sv
test/tb.sv
